FILE: src/fqp_pkg.sv
// shared constants, codes and types for the fastq record parser
package fqp_pkg;

    // width of the base and quality counters
    localparam int COUNT_WIDTH = 16;
    localparam int LEN_WIDTH   = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // parse phase codes
    localparam logic [2:0] PH_AWAIT  = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_BSTART = 3'd2;
    localparam logic [2:0] PH_BASES  = 3'd3;
    localparam logic [2:0] PH_PLUS   = 3'd4;
    localparam logic [2:0] PH_QUAL   = 3'd5;
    localparam logic [2:0] PH_SKIP   = 3'd6;

    // byte roles
    localparam logic [1:0] ROLE_HEADER  = 2'd0;
    localparam logic [1:0] ROLE_BASE    = 2'd1;
    localparam logic [1:0] ROLE_QUAL    = 2'd2;
    localparam logic [1:0] ROLE_FRAMING = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MISSING_AT = 2'd1;
    localparam logic [1:0] ERR_MISMATCH  = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    // special characters
    localparam logic [7:0] CH_AT   = 8'd64;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;

    // one result item
    typedef struct packed {
        logic [LEN_WIDTH-1:0] read_length;
        logic [1:0]           error_code;
        logic                 record_end;
        logic [1:0]           role;
        logic [7:0]           byte_out;
    } result_t;

    // saturating counter increment
    function automatic count_t sat_inc(input count_t v);
        count_t r;
        if (v == '1)
        begin
            r = v;
        end
        else
        begin
            r = v + count_t'(1);
        end
        return r;
    endfunction

    // clamp a count to the width of the read length field
    function automatic logic [LEN_WIDTH-1:0] clamp_len(input count_t v);
        logic [32:0] ext;
        logic [LEN_WIDTH-1:0] r;
        ext = 33'(v);
        if (ext > 33'({LEN_WIDTH{1'b1}}))
        begin
            r = '1;
        end
        else
        begin
            r = ext[LEN_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/fqp_core.sv
// parse state registers and the per-byte classification logic
module fqp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [7:0]       data_byte,
    input  logic             end_of_file,
    output fqp_pkg::result_t result
);

    logic [2:0]      phase_reg;
    logic [2:0]      phase_next;
    fqp_pkg::count_t bases_reg;
    fqp_pkg::count_t bases_next;
    fqp_pkg::count_t quals_reg;
    fqp_pkg::count_t quals_next;
    logic            is_lf;
    logic            is_cr;
    logic            quals_ge;
    logic            counts_eq;

    assign is_lf     = (data_byte == fqp_pkg::CH_LF);
    assign is_cr     = (data_byte == fqp_pkg::CH_CR);
    assign quals_ge  = (quals_reg >= bases_reg);
    assign counts_eq = (quals_reg == bases_reg);

    // next state and result for one item
    always_comb
    begin
        phase_next         = phase_reg;
        bases_next         = bases_reg;
        quals_next         = quals_reg;
        result.byte_out    = end_of_file ? 8'd0 : data_byte;
        result.role        = fqp_pkg::ROLE_FRAMING;
        result.record_end  = 1'b0;
        result.error_code  = fqp_pkg::ERR_NONE;
        result.read_length = '0;

        if (end_of_file)
        begin
            case (phase_reg)
                fqp_pkg::PH_HEADER,
                fqp_pkg::PH_BSTART,
                fqp_pkg::PH_BASES,
                fqp_pkg::PH_PLUS:
                begin
                    result.error_code = fqp_pkg::ERR_TRUNCATED;
                end
                fqp_pkg::PH_QUAL:
                begin
                    if (!quals_ge)
                    begin
                        result.error_code = fqp_pkg::ERR_TRUNCATED;
                    end
                    else if (counts_eq)
                    begin
                        result.record_end  = 1'b1;
                        result.read_length = fqp_pkg::clamp_len(bases_reg);
                    end
                    else
                    begin
                        result.error_code = fqp_pkg::ERR_MISMATCH;
                    end
                end
                default:
                begin
                end
            endcase
            phase_next = fqp_pkg::PH_AWAIT;
            bases_next = '0;
            quals_next = '0;
        end
        else if (!is_cr)
        begin
            case (phase_reg)
                fqp_pkg::PH_AWAIT:
                begin
                    if (data_byte == fqp_pkg::CH_AT)
                    begin
                        bases_next = '0;
                        quals_next = '0;
                        phase_next = fqp_pkg::PH_HEADER;
                    end
                    else
                    begin
                        result.error_code = fqp_pkg::ERR_MISSING_AT;
                        if (!is_lf)
                        begin
                            phase_next = fqp_pkg::PH_SKIP;
                        end
                    end
                end
                fqp_pkg::PH_HEADER:
                begin
                    if (is_lf)
                    begin
                        phase_next = fqp_pkg::PH_BSTART;
                    end
                    else
                    begin
                        result.role = fqp_pkg::ROLE_HEADER;
                    end
                end
                fqp_pkg::PH_BSTART,
                fqp_pkg::PH_BASES:
                begin
                    if (is_lf)
                    begin
                        phase_next = fqp_pkg::PH_BSTART;
                    end
                    else if (phase_reg == fqp_pkg::PH_BSTART
                             && data_byte == fqp_pkg::CH_PLUS)
                    begin
                        phase_next = fqp_pkg::PH_PLUS;
                    end
                    else
                    begin
                        result.role = fqp_pkg::ROLE_BASE;
                        bases_next  = fqp_pkg::sat_inc(bases_reg);
                        phase_next  = fqp_pkg::PH_BASES;
                    end
                end
                fqp_pkg::PH_PLUS:
                begin
                    if (is_lf)
                    begin
                        phase_next = fqp_pkg::PH_QUAL;
                    end
                end
                fqp_pkg::PH_QUAL:
                begin
                    if (is_lf)
                    begin
                        // line end closes the record once qualities catch up
                        if (quals_ge)
                        begin
                            if (counts_eq)
                            begin
                                result.record_end  = 1'b1;
                                result.read_length = fqp_pkg::clamp_len(bases_reg);
                            end
                            else
                            begin
                                result.error_code = fqp_pkg::ERR_MISMATCH;
                            end
                            phase_next = fqp_pkg::PH_AWAIT;
                            bases_next = '0;
                            quals_next = '0;
                        end
                    end
                    else
                    begin
                        result.role = fqp_pkg::ROLE_QUAL;
                        quals_next  = fqp_pkg::sat_inc(quals_reg);
                    end
                end
                default:
                begin
                    if (is_lf)
                    begin
                        phase_next = fqp_pkg::PH_AWAIT;
                    end
                end
            endcase
        end
    end

    // parse state, advanced once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fqp_pkg::PH_AWAIT;
            bases_reg <= '0;
            quals_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            bases_reg <= bases_next;
            quals_reg <= quals_next;
        end
    end

endmodule

FILE: src/fastq_record_parser.sv
// top level of the fastq record parser: input register, parser core, result register
// Classes a FASTQ text stream byte by byte as header, base, quality or framing and
// flags record ends, read lengths and format errors. One item is accepted every
// cycle when the output side keeps up; each item produces exactly one result item,
// which passes through the input register and then the result register that
// bracket the single pass of parse logic. An end-of-file item (tuser bit 0)
// closes or aborts the current record and returns the parser to its reset state.
module fastq_record_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] byte_out, [23:8] read_length
    output logic [3:0]  m_axis_tuser,   // [1:0] role, [3:2] error_code
    output logic        m_axis_tlast    // record_end
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_eof_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    fqp_pkg::result_t  out_res_reg;
    fqp_pkg::result_t  core_res;
    logic              advance;
    logic              s_accept;
    logic              step_en;

    // pipeline moves when the result register is free or being emptied
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign step_en       = advance && in_valid_reg;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // parse logic and state
    fqp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .data_byte   (in_byte_reg),
        .end_of_file (in_eof_reg),
        .result      (core_res)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eof_reg  <= s_axis_tuser[0];
        end
        if (step_en)
        begin
            out_res_reg <= core_res;
        end
    end

    // result item on the output stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.read_length, out_res_reg.byte_out};
    assign m_axis_tuser  = {out_res_reg.error_code, out_res_reg.role};
    assign m_axis_tlast  = out_res_reg.record_end;

endmodule

FILE: bench/fastq_record_parser_test.sv
// self-checking testbench for the fastq record parser: directed records and random text
`timescale 1ns / 1ps

module fastq_record_parser_test;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 600;
    localparam logic [7:0] CH_BASE_A = 8'h41;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;      // [7:0] data_byte
    logic [0:0]  s_axis_tuser = 1'b0;       // [0] end_of_file
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;              // [7:0] byte_out, [23:8] read_length
    logic [3:0]  m_axis_tuser;              // [1:0] role, [3:2] error_code
    logic        m_axis_tlast;              // record_end

    // parser state as the bench tracks it
    logic [2:0]      parse_state = fqp_pkg::PH_AWAIT;
    fqp_pkg::count_t base_count = '0;
    fqp_pkg::count_t qual_count = '0;

    fqp_pkg::result_t expected_results[$];
    logic [7:0] record_bytes[$];
    bit         idle_on = 1'b1;
    int         items_sent = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         stall_left = 0;

    fastq_record_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 11);
        end
        m_axis_tready <= (stall_left == 0);
    end

    // close the quality section: matching counts end the record, else a mismatch
    function void close_record(inout fqp_pkg::result_t r);
        longint unsigned n;
        n = base_count;
        if (qual_count == base_count)
        begin
            r.record_end  = 1'b1;
            r.read_length = (n > ((64'd1 << fqp_pkg::LEN_WIDTH) - 1)) ? '1
                                                                     : n[fqp_pkg::LEN_WIDTH-1:0];
        end
        else
        begin
            r.error_code = fqp_pkg::ERR_MISMATCH;
        end
        parse_state = fqp_pkg::PH_AWAIT;
        base_count  = '0;
        qual_count  = '0;
    endfunction

    // expected result of one accepted item, advancing the tracked state
    function fqp_pkg::result_t classify_byte(input logic [7:0] b, input logic eof);
        fqp_pkg::result_t r;
        r = '0;
        r.role = fqp_pkg::ROLE_FRAMING;
        r.byte_out = eof ? 8'h00 : b;
        if (eof)
        begin
            case (parse_state)
                fqp_pkg::PH_HEADER, fqp_pkg::PH_BSTART, fqp_pkg::PH_BASES, fqp_pkg::PH_PLUS:
                    r.error_code = fqp_pkg::ERR_TRUNCATED;
                fqp_pkg::PH_QUAL:
                    if (qual_count >= base_count)
                        close_record(r);
                    else
                        r.error_code = fqp_pkg::ERR_TRUNCATED;
                default:
                    ;
            endcase
            parse_state = fqp_pkg::PH_AWAIT;
            base_count  = '0;
            qual_count  = '0;
        end
        else if (b != fqp_pkg::CH_CR)
        begin
            case (parse_state)
                fqp_pkg::PH_AWAIT:
                    if (b == fqp_pkg::CH_AT)
                    begin
                        base_count  = '0;
                        qual_count  = '0;
                        parse_state = fqp_pkg::PH_HEADER;
                    end
                    else
                    begin
                        r.error_code = fqp_pkg::ERR_MISSING_AT;
                        if (b != fqp_pkg::CH_LF)
                            parse_state = fqp_pkg::PH_SKIP;
                    end
                fqp_pkg::PH_HEADER:
                    if (b == fqp_pkg::CH_LF)
                        parse_state = fqp_pkg::PH_BSTART;
                    else
                        r.role = fqp_pkg::ROLE_HEADER;
                fqp_pkg::PH_BSTART, fqp_pkg::PH_BASES:
                    if (b == fqp_pkg::CH_LF)
                        parse_state = fqp_pkg::PH_BSTART;
                    else if (parse_state == fqp_pkg::PH_BSTART && b == fqp_pkg::CH_PLUS)
                        parse_state = fqp_pkg::PH_PLUS;
                    else
                    begin
                        r.role = fqp_pkg::ROLE_BASE;
                        if (base_count != '1)
                            base_count = base_count + fqp_pkg::count_t'(1);
                        parse_state = fqp_pkg::PH_BASES;
                    end
                fqp_pkg::PH_PLUS:
                    if (b == fqp_pkg::CH_LF)
                        parse_state = fqp_pkg::PH_QUAL;
                fqp_pkg::PH_QUAL:
                    if (b == fqp_pkg::CH_LF)
                    begin
                        if (qual_count >= base_count)
                            close_record(r);
                    end
                    else
                    begin
                        r.role = fqp_pkg::ROLE_QUAL;
                        if (qual_count != '1)
                            qual_count = qual_count + fqp_pkg::count_t'(1);
                    end
                default:
                    if (b == fqp_pkg::CH_LF)
                        parse_state = fqp_pkg::PH_AWAIT;
            endcase
        end
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_results
        fqp_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item arrived with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[7:0] !== want.byte_out)
                begin
                    $error("byte_out: expected %0d, got %0d", want.byte_out, m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_axis_tuser[1:0] !== want.role)
                begin
                    $error("role: expected %0d, got %0d", want.role, m_axis_tuser[1:0]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.record_end)
                begin
                    $error("record_end: expected %0d, got %0d", want.record_end, m_axis_tlast);
                    mismatch_count++;
                end
                if (m_axis_tuser[3:2] !== want.error_code)
                begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, m_axis_tuser[3:2]);
                    mismatch_count++;
                end
                if (m_axis_tdata[23:8] !== want.read_length)
                begin
                    $error("read_length: expected %0d, got %0d",
                           want.read_length, m_axis_tdata[23:8]);
                    mismatch_count++;
                end
            end
        end
    end

    // send one item, with an optional idle gap in front
    task automatic push_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= b;
        s_axis_tuser  <= eof;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(classify_byte(b, eof));
        items_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    task automatic push_record_bytes(input int count);
        for (int i = 0; i < count; i++)
            push_byte(record_bytes[i], 1'b0);
    endtask

    // any byte but a line end
    function logic [7:0] text_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == fqp_pkg::CH_LF || c == fqp_pkg::CH_CR)
            c = CH_BASE_A;
        return c;
    endfunction

    function void end_line();
        if ($urandom_range(0, 3) == 0)
            record_bytes.push_back(fqp_pkg::CH_CR);
        record_bytes.push_back(fqp_pkg::CH_LF);
    endfunction

    // one record with random content; now and then the quality count is off by one
    function void build_record();
        int lines;
        int len;
        int n_bases;
        int n_quals;
        int take;
        logic [7:0] c;
        record_bytes.delete();
        record_bytes.push_back(fqp_pkg::CH_AT);
        len = $urandom_range(0, 6);
        repeat (len) record_bytes.push_back(text_byte());
        end_line();
        n_bases = 0;
        lines = $urandom_range(1, 3);
        repeat (lines)
        begin
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
            begin
                c = text_byte();
                if (i == 0 && c == fqp_pkg::CH_PLUS)
                    c = CH_BASE_A;
                record_bytes.push_back(c);
            end
            n_bases += len;
            end_line();
        end
        record_bytes.push_back(fqp_pkg::CH_PLUS);
        len = $urandom_range(0, 3);
        repeat (len) record_bytes.push_back(text_byte());
        end_line();
        n_quals = n_bases;
        case ($urandom_range(0, 9))
            0: n_quals++;
            1: if (n_quals > 0) n_quals--;
            default: ;
        endcase
        lines = $urandom_range(1, 3);
        for (int k = 0; k < lines; k++)
        begin
            take = (k == lines - 1) ? n_quals : $urandom_range(0, n_quals);
            repeat (take) record_bytes.push_back(text_byte());
            n_quals -= take;
            end_line();
        end
    endfunction

    // multi-line bases and qualities, a CR, an empty base line and '+' text
    task automatic test_well_formed_record();
        push_text("@r\015\nA\n\nG\n+x\n!\n!\n");
        push_text("@\n+\n\n");
    endtask

    // lowest and highest byte values in the bases and qualities, highest in the header
    task automatic test_byte_extremes();
        push_text("@");
        push_byte(8'hFF, 1'b0);
        push_text("\n");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("\n+\n");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("\n");
    endtask

    // blank line and junk line where a header should start
    task automatic test_bad_line_start();
        push_text("\nX");
        push_byte(8'hFF, 1'b0);
        push_text("\n");
    endtask

    // too many qualities
    task automatic test_count_mismatch();
        push_text("@\nA\n+\n!!\n");
    endtask

    // end of file in the header, as a final line end, short of qualities, and while idle
    task automatic test_end_of_file();
        push_text("@h");
        push_byte(8'hFF, 1'b1);
        push_text("@\nA\n+\n!");
        push_byte(8'h00, 1'b1);
        push_text("@\nAA\n+\n!");
        push_byte(8'h5A, 1'b1);
        push_byte(8'hFF, 1'b1);
    endtask

    // mostly well-formed records, plus truncated ones, stray lines and bare end of file
    task automatic test_random_text();
        int start;
        int pick;
        int count;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (RANDOM_ITEMS - (items_sent - start) < 80)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                build_record();
                push_record_bytes(record_bytes.size());
            end
            else if (pick < 88)
            begin
                // final line end dropped, or cut anywhere, then end of file
                build_record();
                if (pick < 78)
                    count = record_bytes.size() - 1;
                else
                    count = $urandom_range(1, record_bytes.size() - 1);
                push_record_bytes(count);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (pick < 98)
            begin
                count = $urandom_range(1, 6);
                repeat (count) push_byte(8'($urandom_range(0, 255)), 1'b0);
                push_byte(fqp_pkg::CH_LF, 1'b0);
            end
            else
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_well_formed_record();
        test_byte_extremes();
        test_bad_line_start();
        test_count_mismatch();
        test_end_of_file();
        test_random_text();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
